/* src/psg_pkg.sv */
// shared types, constants and arithmetic helpers for the point spread gate
`timescale 1ns / 1ps

package psg_pkg;

    // window geometry
    localparam int WINDOW_DEPTH = 10;
    localparam int COORD_BITS   = 12;
    localparam int SLOT_BITS    = $clog2(WINDOW_DEPTH);
    localparam int FILL_BITS    = $clog2(WINDOW_DEPTH + 1);
    localparam int DEPTH_LOG2   = $clog2(WINDOW_DEPTH);

    // field widths
    localparam int SPREAD_BITS   = 13;
    localparam int MAX_SPREAD_RESET = 35;
    localparam int SPREAD_SAT    = (1 << SPREAD_BITS) - 1;
    localparam int IN_DATA_BITS  = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = ((2 * COORD_BITS + SPREAD_BITS + 7) / 8) * 8;

    // configuration port
    localparam int APB_ADDR_BITS  = 3;
    localparam int APB_DATA_BITS  = 32;
    localparam logic [APB_ADDR_BITS-1:0] ADDR_MAX_SPREAD = 3'd0;

    // arithmetic widths
    localparam int SUM_BITS        = COORD_BITS + DEPTH_LOG2;
    localparam int SQ_BITS         = 2 * COORD_BITS;
    localparam int ROOT_BITS       = COORD_BITS + 1;
    localparam int SQRT_PER_CYCLE  = 4;
    localparam int SQRT_CYCLES     = (ROOT_BITS + SQRT_PER_CYCLE - 1) / SQRT_PER_CYCLE;
    localparam int ROOT_PAD        = SQRT_CYCLES * SQRT_PER_CYCLE;
    localparam int RAD_BITS        = 2 * ROOT_PAD;
    localparam int REM_BITS        = ROOT_PAD + 2;
    localparam int STEP_BITS       = (SQRT_CYCLES > 1) ? $clog2(SQRT_CYCLES) : 1;
    localparam int DIST_BITS       = ROOT_BITS + DEPTH_LOG2;
    localparam int DIV_BITS        = (SUM_BITS > DIST_BITS) ? SUM_BITS : DIST_BITS;

    // divide by window depth through a reciprocal, exact for any DIV_BITS input
    localparam int RECIP_SHIFT = DIV_BITS + DEPTH_LOG2;
    localparam int RECIP       = ((1 << RECIP_SHIFT) + WINDOW_DEPTH - 1) / WINDOW_DEPTH;
    localparam int RECIP_BITS  = DIV_BITS + 1;
    localparam int PROD_BITS   = DIV_BITS + RECIP_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_MEAN,
        ST_DIFF,
        ST_RAD,
        ST_ROOT,
        ST_DIV,
        ST_EMIT
    } psg_state_t;

    typedef struct packed {
        logic                 capture;
        logic                 store;
        logic                 store_zero;
        logic [SLOT_BITS-1:0] slot;
        logic [SLOT_BITS-1:0] idx;
        logic                 sum_clr;
        logic                 sum_en;
        logic                 mean_en;
        logic                 diff_en;
        logic                 rad_en;
        logic                 root_en;
        logic                 root_last;
        logic                 div_en;
        logic                 load_out;
        logic                 fill_res;
    } psg_cmd_t;

    typedef struct packed {
        logic out_full;
    } psg_stat_t;

    typedef struct packed {
        logic [REM_BITS-1:0] rem;
        logic [ROOT_PAD-1:0] root;
        logic [RAD_BITS-1:0] rad;
    } sqrt_t;

    function automatic logic [DIV_BITS-1:0] div_depth(input logic [DIV_BITS-1:0] v);
        logic [PROD_BITS-1:0] prod;
        prod = PROD_BITS'(v) * PROD_BITS'(RECIP);
        return DIV_BITS'(prod >> RECIP_SHIFT);
    endfunction

    // one restoring square root step: one root bit per call
    function automatic sqrt_t sqrt_step(input sqrt_t s);
        sqrt_t               r;
        logic [REM_BITS-1:0] shifted;
        logic [REM_BITS-1:0] trial;
        shifted = {s.rem[REM_BITS-3:0], s.rad[RAD_BITS-1 -: 2]};
        trial   = {s.root, 2'b01};
        r.rad   = {s.rad[RAD_BITS-3:0], 2'b00};
        if (shifted >= trial)
        begin
            r.rem  = shifted - trial;
            r.root = {s.root[ROOT_PAD-2:0], 1'b1};
        end
        else
        begin
            r.rem  = shifted;
            r.root = {s.root[ROOT_PAD-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

/* src/psg_ctrl.sv */
// sequencing state machine: slot and fill bookkeeping, window sweeps
`timescale 1ns / 1ps

module psg_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_detected,
    output logic                in_ready,
    input  psg_pkg::psg_stat_t  stat,
    output psg_pkg::psg_cmd_t   cmd
);

    localparam logic [psg_pkg::SLOT_BITS-1:0] LAST_IDX =
        psg_pkg::SLOT_BITS'(psg_pkg::WINDOW_DEPTH - 1);
    localparam logic [psg_pkg::FILL_BITS-1:0] FULL_COUNT =
        psg_pkg::FILL_BITS'(psg_pkg::WINDOW_DEPTH);
    localparam logic [psg_pkg::STEP_BITS-1:0] LAST_STEP =
        psg_pkg::STEP_BITS'(psg_pkg::SQRT_CYCLES - 1);

    psg_pkg::psg_state_t               state_reg, state_next;
    logic [psg_pkg::SLOT_BITS-1:0]     idx_reg, idx_next;
    logic [psg_pkg::SLOT_BITS-1:0]     slot_reg, slot_next;
    logic [psg_pkg::FILL_BITS-1:0]     fill_reg, fill_next;
    logic [psg_pkg::STEP_BITS-1:0]     step_reg, step_next;
    logic                              fill_res_reg, fill_res_next;
    logic                              accept;
    logic                              full;

    assign full   = (fill_reg == FULL_COUNT);
    assign accept = in_valid && in_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            psg_pkg::ST_IDLE:
            begin
                if (accept && in_detected)
                    state_next = full ? psg_pkg::ST_SUM : psg_pkg::ST_EMIT;
            end
            psg_pkg::ST_SUM:
            begin
                if (idx_reg == LAST_IDX)
                    state_next = psg_pkg::ST_MEAN;
            end
            psg_pkg::ST_MEAN: state_next = psg_pkg::ST_DIFF;
            psg_pkg::ST_DIFF: state_next = psg_pkg::ST_RAD;
            psg_pkg::ST_RAD:  state_next = psg_pkg::ST_ROOT;
            psg_pkg::ST_ROOT:
            begin
                if (step_reg == LAST_STEP)
                    state_next = (idx_reg == LAST_IDX) ? psg_pkg::ST_DIV : psg_pkg::ST_DIFF;
            end
            psg_pkg::ST_DIV:  state_next = psg_pkg::ST_EMIT;
            psg_pkg::ST_EMIT:
            begin
                if (!stat.out_full)
                    state_next = psg_pkg::ST_IDLE;
            end
            default: state_next = psg_pkg::ST_IDLE;
        endcase
    end

    // outputs and counters
    always_comb
    begin
        in_ready      = 1'b0;
        cmd           = '0;
        cmd.slot      = slot_reg;
        cmd.idx       = idx_reg;
        cmd.fill_res  = fill_res_reg;
        idx_next      = idx_reg;
        slot_next     = slot_reg;
        fill_next     = fill_reg;
        step_next     = step_reg;
        fill_res_next = fill_res_reg;
        unique case (state_reg)
            psg_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (accept)
                begin
                    cmd.capture    = 1'b1;
                    cmd.store      = in_detected || full;
                    cmd.store_zero = !in_detected;
                    slot_next      = (slot_reg == LAST_IDX) ? '0 : slot_reg + 1'b1;
                    idx_next       = '0;
                    if (in_detected)
                    begin
                        fill_res_next = !full;
                        cmd.sum_clr   = full;
                        if (!full)
                            fill_next = fill_reg + 1'b1;
                    end
                end
            end
            psg_pkg::ST_SUM:
            begin
                cmd.sum_en = 1'b1;
                idx_next   = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
            end
            psg_pkg::ST_MEAN: cmd.mean_en = 1'b1;
            psg_pkg::ST_DIFF: cmd.diff_en = 1'b1;
            psg_pkg::ST_RAD:
            begin
                cmd.rad_en = 1'b1;
                step_next  = '0;
            end
            psg_pkg::ST_ROOT:
            begin
                cmd.root_en = 1'b1;
                step_next   = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    cmd.root_last = 1'b1;
                    if (idx_reg != LAST_IDX)
                        idx_next = idx_reg + 1'b1;
                end
            end
            psg_pkg::ST_DIV:  cmd.div_en = 1'b1;
            psg_pkg::ST_EMIT: cmd.load_out = !stat.out_full;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= psg_pkg::ST_IDLE;
            idx_reg      <= '0;
            slot_reg     <= '0;
            fill_reg     <= '0;
            step_reg     <= '0;
            fill_res_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            slot_reg     <= slot_next;
            fill_reg     <= fill_next;
            step_reg     <= step_next;
            fill_res_reg <= fill_res_next;
        end
    end

endmodule

/* src/psg_datapath.sv */
// window store, mean, distance square roots, spread and output register
`timescale 1ns / 1ps

module psg_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  psg_pkg::psg_cmd_t                 cmd,
    output psg_pkg::psg_stat_t                stat,
    input  logic [psg_pkg::COORD_BITS-1:0]    in_x,
    input  logic [psg_pkg::COORD_BITS-1:0]    in_y,
    input  logic [psg_pkg::SPREAD_BITS-1:0]   max_spread,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [psg_pkg::COORD_BITS-1:0]    out_x,
    output logic [psg_pkg::COORD_BITS-1:0]    out_y,
    output logic                              out_accepted,
    output logic [psg_pkg::SPREAD_BITS-1:0]   out_spread
);

    logic [psg_pkg::COORD_BITS-1:0]  win_x_reg [psg_pkg::WINDOW_DEPTH];
    logic [psg_pkg::COORD_BITS-1:0]  win_y_reg [psg_pkg::WINDOW_DEPTH];
    logic [psg_pkg::COORD_BITS-1:0]  pt_x_reg, pt_y_reg;
    logic [psg_pkg::SUM_BITS-1:0]    sum_x_reg, sum_y_reg;
    logic [psg_pkg::COORD_BITS-1:0]  mean_x_reg, mean_y_reg;
    logic [psg_pkg::SQ_BITS-1:0]     sq_x_reg, sq_y_reg;
    psg_pkg::sqrt_t                  sqrt_reg, sqrt_next;
    logic [psg_pkg::DIST_BITS-1:0]   dist_reg;
    logic [psg_pkg::SPREAD_BITS-1:0] spread_reg;
    logic                            pass_reg;
    logic                            out_valid_reg;
    logic [psg_pkg::COORD_BITS-1:0]  out_x_reg, out_y_reg;
    logic                            out_acc_reg;
    logic [psg_pkg::SPREAD_BITS-1:0] out_spread_reg;

    logic [psg_pkg::COORD_BITS-1:0]  rd_x, rd_y;
    logic [psg_pkg::COORD_BITS-1:0]  dx, dy;
    logic [psg_pkg::DIV_BITS-1:0]    mean_x_q, mean_y_q, spread_q;

    assign rd_x = win_x_reg[cmd.idx];
    assign rd_y = win_y_reg[cmd.idx];

    assign dx = (mean_x_reg >= rd_x) ? mean_x_reg - rd_x : rd_x - mean_x_reg;
    assign dy = (mean_y_reg >= rd_y) ? mean_y_reg - rd_y : rd_y - mean_y_reg;

    assign mean_x_q = psg_pkg::div_depth(psg_pkg::DIV_BITS'(sum_x_reg));
    assign mean_y_q = psg_pkg::div_depth(psg_pkg::DIV_BITS'(sum_y_reg));
    assign spread_q = psg_pkg::div_depth(psg_pkg::DIV_BITS'(dist_reg));

    // several root bits per cycle
    always_comb
    begin
        sqrt_next = sqrt_reg;
        for (int k = 0; k < psg_pkg::SQRT_PER_CYCLE; k++)
            sqrt_next = psg_pkg::sqrt_step(sqrt_next);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            win_x_reg[cmd.slot] <= cmd.store_zero ? '0 : in_x;
            win_y_reg[cmd.slot] <= cmd.store_zero ? '0 : in_y;
        end
        if (cmd.capture)
        begin
            pt_x_reg <= in_x;
            pt_y_reg <= in_y;
        end
        if (cmd.sum_clr)
        begin
            sum_x_reg <= '0;
            sum_y_reg <= '0;
        end
        else if (cmd.sum_en)
        begin
            sum_x_reg <= sum_x_reg + psg_pkg::SUM_BITS'(rd_x);
            sum_y_reg <= sum_y_reg + psg_pkg::SUM_BITS'(rd_y);
        end
        if (cmd.mean_en)
        begin
            mean_x_reg <= mean_x_q[psg_pkg::COORD_BITS-1:0];
            mean_y_reg <= mean_y_q[psg_pkg::COORD_BITS-1:0];
        end
        if (cmd.diff_en)
        begin
            sq_x_reg <= psg_pkg::SQ_BITS'(dx) * psg_pkg::SQ_BITS'(dx);
            sq_y_reg <= psg_pkg::SQ_BITS'(dy) * psg_pkg::SQ_BITS'(dy);
        end
        if (cmd.rad_en)
        begin
            sqrt_reg.rem  <= '0;
            sqrt_reg.root <= '0;
            sqrt_reg.rad  <= psg_pkg::RAD_BITS'(sq_x_reg) + psg_pkg::RAD_BITS'(sq_y_reg);
        end
        else if (cmd.root_en)
            sqrt_reg <= sqrt_next;
        if (cmd.mean_en)
            dist_reg <= '0;
        else if (cmd.root_last)
            dist_reg <= dist_reg + psg_pkg::DIST_BITS'(sqrt_next.root);
        if (cmd.div_en)
        begin
            pass_reg   <= (spread_q <= psg_pkg::DIV_BITS'(max_spread));
            spread_reg <= (spread_q > psg_pkg::DIV_BITS'(psg_pkg::SPREAD_SAT))
                          ? psg_pkg::SPREAD_BITS'(psg_pkg::SPREAD_SAT)
                          : spread_q[psg_pkg::SPREAD_BITS-1:0];
        end
        if (cmd.load_out)
        begin
            if (cmd.fill_res)
            begin
                out_x_reg      <= '0;
                out_y_reg      <= '0;
                out_acc_reg    <= 1'b0;
                out_spread_reg <= '0;
            end
            else
            begin
                out_x_reg      <= pass_reg ? pt_x_reg : '0;
                out_y_reg      <= pass_reg ? pt_y_reg : '0;
                out_acc_reg    <= pass_reg;
                out_spread_reg <= spread_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign stat.out_full = out_valid_reg && !out_ready;
    assign out_valid     = out_valid_reg;
    assign out_x         = out_x_reg;
    assign out_y         = out_y_reg;
    assign out_accepted  = out_acc_reg;
    assign out_spread    = out_spread_reg;

endmodule

/* src/point_spread_gate.sv */
// top level of the point spread gate: stream channels and register port
`timescale 1ns / 1ps

// point_spread_gate
// one input transfer per frame on the s_ channel: s_tuser is the detected flag,
// s_tdata the x,y point; results leave on the m_ channel, m_tuser the accept flag
// a sliding window of ten points is kept; the write slot moves on every frame
// while filling, a detection is stored and gives a zero result marked rejected;
// a miss while filling gives nothing
// once full, a miss zeroes the current slot and gives no result;
// a detection is stored, then the mean, ten distance square roots and the
// spread are worked out in order: the sum sweep, the mean, for each of the ten
// points a diff/square/root pass, then division and output load; after a
// detection s_tready stays low until its result is loaded, so the next input
// transfer waits for it; a fill-phase detection goes straight to output load
// the square root unit resolves four root bits a cycle, one point at a time
// s_tready is high whenever the sequencer is idle, even with a result waiting
// on the m_ side; a stalled receiver only holds the sequencer in its last step
// reset clears slot, fill count, sequencer and output valid; max_spread resets to 35;
// window contents are undefined until written; max_spread must be written by the user
// over the register port only while the block is idle; the block does not enforce it

module point_spread_gate (
    input  logic                                clk,
    input  logic                                rst_n,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [psg_pkg::IN_DATA_BITS-1:0]    s_tdata,   // pos_x [11:0], pos_y [23:12]
    input  logic                                s_tuser,   // detected
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [psg_pkg::OUT_DATA_BITS-1:0]   m_tdata,   // out_x [11:0], out_y [23:12],
                                                           // spread [36:24], zero fill above
    output logic                                m_tuser,   // accepted
    // register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [psg_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [psg_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [psg_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                pready
);

    psg_pkg::psg_cmd_t                cmd;
    psg_pkg::psg_stat_t               stat;
    logic [psg_pkg::SPREAD_BITS-1:0]  max_spread_reg;
    logic [psg_pkg::COORD_BITS-1:0]   out_x, out_y;
    logic [psg_pkg::SPREAD_BITS-1:0]  out_spread;
    logic                             cfg_write;

    // register port: no wait states, write at the access phase
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr == psg_pkg::ADDR_MAX_SPREAD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_spread_reg <= psg_pkg::SPREAD_BITS'(psg_pkg::MAX_SPREAD_RESET);
        else if (cfg_write)
            max_spread_reg <= pwdata[psg_pkg::SPREAD_BITS-1:0];
    end

    // read back, unmapped addresses read as zero
    always_comb
    begin
        prdata = '0;
        unique case (paddr)
            psg_pkg::ADDR_MAX_SPREAD: prdata = psg_pkg::APB_DATA_BITS'(max_spread_reg);
            default:                  prdata = '0;
        endcase
    end

    // sequencer
    psg_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_detected (s_tuser),
        .in_ready    (s_tready),
        .stat        (stat),
        .cmd         (cmd)
    );

    // arithmetic and result register
    psg_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .in_x         (s_tdata[psg_pkg::COORD_BITS-1:0]),
        .in_y         (s_tdata[2*psg_pkg::COORD_BITS-1:psg_pkg::COORD_BITS]),
        .max_spread   (max_spread_reg),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_x        (out_x),
        .out_y        (out_y),
        .out_accepted (m_tuser),
        .out_spread   (out_spread)
    );

    // result packing, first field lowest
    assign m_tdata = psg_pkg::OUT_DATA_BITS'({out_spread, out_y, out_x});

endmodule
